@@ hdl/dtnd_pkg.sv @@
// Shared types and constants of the drum trigger note detector.
// Used by the interfaces, the event queue and the top level; no dependencies.
package dtnd_pkg;

  localparam int unsigned NOTE_W  = 7;
  localparam int unsigned VEL_W   = 7;
  localparam int unsigned MCH_W   = 4;
  localparam int unsigned SMP_W   = 8;
  localparam int unsigned CH_W    = 2;
  localparam int unsigned ADDR_W  = 4;
  localparam int unsigned DATA_W  = 32;

  // Event queue: room for two full items of results.
  localparam int unsigned QDEPTH  = 4;
  localparam int unsigned QPTR_W  = 2;
  localparam int unsigned QCNT_W  = 3;

  localparam logic [SMP_W-1:0]  THRESHOLD_RST = 8'd6;
  localparam logic [SMP_W-1:0]  GUARD_RST     = 8'd60;
  localparam logic [NOTE_W-1:0] BASE_NOTE_RST = 7'd40;
  localparam logic [MCH_W-1:0]  MIDI_CH_RST   = 4'd3;
  localparam logic [SMP_W-1:0]  HOLD_FULL     = 8'd255;
  localparam logic [NOTE_W-1:0] NOTE_MAX      = 7'd127;
  localparam logic [VEL_W-1:0]  VEL_MAX       = 7'd127;

  typedef enum logic [1:0] {
    REG_THRESHOLD = 2'd0,
    REG_GUARD     = 2'd1,
    REG_BASE_NOTE = 2'd2,
    REG_MIDI_CH   = 2'd3
  } reg_idx_e;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_TICK   = 1'b1
  } op_e;

  typedef enum logic {
    KIND_OFF = 1'b0,
    KIND_ON  = 1'b1
  } kind_e;

  typedef struct packed {
    logic              kind;
    logic [NOTE_W-1:0] note;
    logic [VEL_W-1:0]  velocity;
    logic [MCH_W-1:0]  out_channel;
    logic              last;
  } evt_t;

  // Queue write side: how many words go in this cycle and what they are.
  typedef struct packed {
    logic [1:0] push_n;
    evt_t       w0;
    evt_t       w1;
  } q_push_t;

endpackage

@@ hdl/dtnd_if.sv @@
// Handshake interfaces for the input and result channels.
// Depends on dtnd_pkg for field widths.
interface dtnd_in_if import dtnd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             op;
  logic [CH_W-1:0]  channel;
  logic [SMP_W-1:0] sample;
  logic             shift;

  modport source (output valid, op, channel, sample, shift, input ready);
  modport sink   (input valid, op, channel, sample, shift, output ready);
endinterface

interface dtnd_out_if import dtnd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [NOTE_W-1:0] note;
  logic [VEL_W-1:0]  velocity;
  logic [MCH_W-1:0]  out_channel;
  logic              last;

  modport source (output valid, kind, note, velocity, out_channel, last, input ready);
  modport sink   (input valid, kind, note, velocity, out_channel, last, output ready);
endinterface

@@ hdl/drum_trigger_note_detector_core.sv @@
// Top level of the drum trigger note detector.
// Depends on dtnd_pkg, dtnd_in_if / dtnd_out_if and dtnd_evt_q.
//
// Usage:
//  - in_i carries one word per item: a sample (op = sample, channel, sample,
//    shift) or a timer tick (op = tick). out_o carries note events (kind,
//    note, velocity, out_channel, last); last marks the final event of an item.
//  - An item produces 0, 1 or 2 events: note-on on a strike (preceded by a
//    note-off when the channel was still sounding), or a note-off when a held
//    channel has run its hold counter down to zero. Ticks give no events.
//  - An accepted word is registered, evaluated against channel state in the
//    next cycle and written to a 4-word event queue, which feeds out_o.
//  - Throughput: one item per cycle while in_i.ready is high. Channel state
//    is updated in the single evaluate stage, so back-to-back items on the
//    same channel see each other's effect. The output side moves one event per
//    cycle, so items that make two events are limited by the result channel.
//  - in_i.ready drops only when the event queue cannot take two more words
//    on top of what is queued and in flight; a stalled receiver fills the queue
//    and then holds the input off. Nothing is lost or dropped.
//  - Reset (rst_ni low, async): registers return to threshold 6, guard 60,
//    base note 40, MIDI channel 3; all channel state clears; queue empties.
//  - Configuration: APB writes at byte addresses 0x0/0x4/0x8/0xC
//    (threshold, guard, base_note, midi_channel); write only while idle.
module drum_trigger_note_detector_core import dtnd_pkg::*; #(
  parameter int unsigned CHANNELS = 3
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  dtnd_in_if.sink           in_i,
  dtnd_out_if.source        out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  // ---------------------------------------------------------------- config
  logic [SMP_W-1:0]  thresh_q;
  logic [SMP_W-1:0]  guard_q;
  logic [NOTE_W-1:0] base_q;
  logic [MCH_W-1:0]  mch_q;
  logic              cfg_wr;
  reg_idx_e          cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= THRESHOLD_RST;
      guard_q  <= GUARD_RST;
      base_q   <= BASE_NOTE_RST;
      mch_q    <= MIDI_CH_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_THRESHOLD: thresh_q <= pwdata[SMP_W-1:0];
        REG_GUARD:     guard_q  <= pwdata[SMP_W-1:0];
        REG_BASE_NOTE: base_q   <= pwdata[NOTE_W-1:0];
        REG_MIDI_CH:   mch_q    <= pwdata[MCH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_THRESHOLD: prdata = DATA_W'(thresh_q);
      REG_GUARD:     prdata = DATA_W'(guard_q);
      REG_BASE_NOTE: prdata = DATA_W'(base_q);
      REG_MIDI_CH:   prdata = DATA_W'(mch_q);
      default:       prdata = '0;
    endcase
  end

  // ----------------------------------------------------------- input stage
  logic              s1_vld_q;
  logic              s1_op_q;
  logic [CH_W-1:0]   s1_ch_q;
  logic [SMP_W-1:0]  s1_smp_q;
  logic              s1_shift_q;
  logic              in_fire;
  logic [QCNT_W-1:0] q_count;
  q_push_t           push;

  // Queue always has room for whatever the evaluate stage produces, since
  // admission reserves two slots beyond the queued and in-flight words.
  assign in_i.ready = (q_count + QCNT_W'(push.push_n)) <= QCNT_W'(QDEPTH - 2);
  assign in_fire    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= in_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_op_q    <= in_i.op;
      s1_ch_q    <= in_i.channel;
      s1_smp_q   <= in_i.sample;
      s1_shift_q <= in_i.shift;
    end
  end

  // ---------------------------------------------------------- channel state
  logic [SMP_W-1:0] prev_q [CHANNELS];
  logic [SMP_W-1:0] hold_q [CHANNELS];
  logic             act_q  [CHANNELS];

  logic             is_smp, is_tick, in_range;
  logic [SMP_W-1:0] prev_sel, hold_sel;
  logic             act_sel;
  logic [8:0]       note_sum;
  logic [NOTE_W-1:0] note;
  logic [VEL_W-1:0] vel;
  logic [8:0]       rise_lim;
  logic             strike, release_ev;
  evt_t             ev_off, ev_on;

  assign is_tick  = s1_vld_q && (s1_op_q == OP_TICK);
  assign in_range = 32'(s1_ch_q) < 32'(CHANNELS);
  assign is_smp   = s1_vld_q && (s1_op_q == OP_SAMPLE) && in_range;

  always_comb begin
    prev_sel = '0;
    hold_sel = '0;
    act_sel  = 1'b0;
    for (int i = 0; i < int'(CHANNELS); i++) begin
      if (32'(s1_ch_q) == 32'(i)) begin
        prev_sel = prev_q[i];
        hold_sel = hold_q[i];
        act_sel  = act_q[i];
      end
    end
  end

  // Note: base + channel (+ channel count for the upper bank), saturated.
  assign note_sum = 9'(base_q) + 9'(s1_ch_q) + (s1_shift_q ? 9'(CHANNELS) : 9'd0);
  assign note     = (note_sum > 9'(NOTE_MAX)) ? NOTE_MAX : note_sum[NOTE_W-1:0];
  // Velocity 2*sample clipped at 127.
  assign vel      = (s1_smp_q[7:6] != 2'b00) ? VEL_MAX : {s1_smp_q[5:0], 1'b0};

  // Rise compare runs one bit wider so a high previous sample blocks strikes.
  assign rise_lim   = 9'(prev_sel) + 9'(thresh_q);
  assign strike     = is_smp && (9'(s1_smp_q) > rise_lim) &&
                      (hold_sel < (HOLD_FULL - guard_q));
  // A strike reloads the counter, so release only happens without a strike.
  assign release_ev = is_smp && !strike && (hold_sel == '0) && act_sel;

  always_comb begin
    ev_off             = '0;
    ev_off.kind        = KIND_OFF;
    ev_off.note        = note;
    ev_off.out_channel = mch_q;
    ev_on              = ev_off;
    ev_on.kind         = KIND_ON;
    ev_on.velocity     = vel;
    ev_on.last         = 1'b1;

    push = '0;
    if (strike && act_sel) begin
      push.push_n = 2'd2;
      push.w0     = ev_off;
      push.w1     = ev_on;
    end else if (strike) begin
      push.push_n = 2'd1;
      push.w0     = ev_on;
    end else if (release_ev) begin
      push.push_n  = 2'd1;
      push.w0      = ev_off;
      push.w0.last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(CHANNELS); i++) begin
        prev_q[i] <= '0;
        hold_q[i] <= '0;
        act_q[i]  <= 1'b0;
      end
    end else begin
      for (int i = 0; i < int'(CHANNELS); i++) begin
        if (is_tick) begin
          if (hold_q[i] != '0) begin
            hold_q[i] <= hold_q[i] - SMP_W'(1);
          end
        end else if (is_smp && (32'(s1_ch_q) == 32'(i))) begin
          prev_q[i] <= release_ev ? '0 : s1_smp_q;
          if (strike) begin
            hold_q[i] <= HOLD_FULL;
            act_q[i]  <= 1'b1;
          end else if (release_ev) begin
            act_q[i]  <= 1'b0;
          end
        end
      end
    end
  end

  // ------------------------------------------------------------ event queue
  evt_t head;
  logic q_nempty;

  dtnd_evt_q u_evt_q (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .pop_i    (out_o.ready),
    .head_o   (head),
    .nempty_o (q_nempty),
    .count_o  (q_count)
  );

  assign out_o.valid       = q_nempty;
  assign out_o.kind        = head.kind;
  assign out_o.note        = head.note;
  assign out_o.velocity    = head.velocity;
  assign out_o.out_channel = head.out_channel;
  assign out_o.last        = head.last;

endmodule

@@ hdl/dtnd_evt_q.sv @@
// Small event queue: takes zero, one or two words per cycle, gives one on pop_i.
// Depends on dtnd_pkg (evt_t, q_push_t, queue sizing).
module dtnd_evt_q import dtnd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  q_push_t           push_i,
  input  logic              pop_i,
  output evt_t              head_o,
  output logic              nempty_o,
  output logic [QCNT_W-1:0] count_o
);

  evt_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              do_pop;

  assign do_pop   = pop_i && (count_q != '0);
  assign wr_ptr_d = wr_ptr_q + QPTR_W'(push_i.push_n);
  assign rd_ptr_d = rd_ptr_q + QPTR_W'(do_pop);
  assign count_d  = count_q + QCNT_W'(push_i.push_n) - QCNT_W'(do_pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push_n != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.w0;
    end
    if (push_i.push_n == 2'd2) begin
      mem_q[wr_ptr_q + QPTR_W'(1)] <= push_i.w1;
    end
  end

  assign head_o   = mem_q[rd_ptr_q];
  assign nempty_o = (count_q != '0);
  assign count_o  = count_q;

endmodule

@@ sim/drum_trigger_note_detector_core_test.sv @@
// Self-checking testbench for drum_trigger_note_detector_core.
// Depends on dtnd_pkg, dtnd_in_if / dtnd_out_if and the core RTL; predicts
// note events from its own copy of the channel state and checks every word.
module drum_trigger_note_detector_core_test;
  import dtnd_pkg::*;

  localparam int unsigned CHANNELS     = 3;
  // Longest run of cycles with no word and no register access moving.
  // The long receiver hold-off, HOLD_OFF_LEN, is the longest; everything else is far shorter.
  localparam int unsigned IDLE_LIMIT   = 4000;
  // Settle time after drain, for words still in the core that make no event.
  localparam int unsigned DRAIN_SETTLE = 4;
  localparam int unsigned HOLD_OFF_LEN = 300;
  localparam int unsigned PHASES       = 3;
  localparam int unsigned PHASE_WORDS  = 80;

  logic              clk_i  = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel   = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr  = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  dtnd_in_if  in_if ();
  dtnd_out_if out_if ();

  drum_trigger_note_detector_core #(.CHANNELS(CHANNELS)) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // ---------------------------------------------------------------------------
  // Shadow of the block: register copies plus per-channel trigger state.
  // ---------------------------------------------------------------------------
  logic [SMP_W-1:0]  rise_thr;
  logic [SMP_W-1:0]  guard_band;
  logic [NOTE_W-1:0] base_note_r;
  logic [MCH_W-1:0]  midi_ch_r;

  logic [SMP_W-1:0]  last_level [CHANNELS];
  logic [SMP_W-1:0]  hold_cnt   [CHANNELS];
  logic              sounding   [CHANNELS];

  // Note events still owed by the core, oldest first.
  evt_t        pending_events [$];
  int unsigned mismatch_cnt = 0;
  int unsigned idle_cycles  = 0;
  // Set for the last stretch of traffic: no gaps on either side.
  bit          calm         = 1'b0;
  // Long receiver hold-off, counted down by the receiver itself.
  int unsigned rx_hold_off  = 0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  task automatic shadow_reset();
    rise_thr    = THRESHOLD_RST;
    guard_band  = GUARD_RST;
    base_note_r = BASE_NOTE_RST;
    midi_ch_r   = MIDI_CH_RST;
    for (int i = 0; i < CHANNELS; i++) begin
      last_level[i] = '0;
      hold_cnt[i]   = '0;
      sounding[i]   = 1'b0;
    end
  endtask

  task automatic report_mismatch(string what, int got_v, int want_v);
    $display("[%0t] mismatch %s: got %0d, expected %0d", $time, what, got_v, want_v);
    mismatch_cnt++;
  endtask

  task automatic check_field(string what, int got_v, int want_v);
    if (got_v != want_v) begin
      report_mismatch(what, got_v, want_v);
    end
  endtask

  function automatic evt_t note_event(kind_e kind, logic [NOTE_W-1:0] note,
                                      logic [VEL_W-1:0] vel);
    evt_t e;
    e.kind        = kind;
    e.note        = note;
    e.velocity    = vel;
    e.out_channel = midi_ch_r;
    e.last        = 1'b0;
    return e;
  endfunction

  // Works out the events of one accepted word and updates the shadow state.
  // At most two events: note-off then note-on on a retrigger. A release can't
  // follow a strike in the same word since the strike reloads the counter.
  task automatic predict_events(op_e op, logic [CH_W-1:0] ch, logic [SMP_W-1:0] smp,
                                logic sh);
    evt_t ev [2];
    int   n;
    int   note_i;
    int   vel_i;
    bit   strike;
    n = 0;
    if (op == OP_TICK) begin
      for (int i = 0; i < CHANNELS; i++) begin
        if (hold_cnt[i] != 0) begin
          hold_cnt[i] = hold_cnt[i] - SMP_W'(1);
        end
      end
    end else if (ch < CHANNELS) begin
      // Shift selects the upper bank, one channel count above.
      note_i = int'(base_note_r) + int'(ch) + (sh ? int'(CHANNELS) : 0);
      if (note_i > int'(NOTE_MAX)) begin
        note_i = int'(NOTE_MAX);
      end
      vel_i = 2 * int'(smp);
      if (vel_i > int'(VEL_MAX)) begin
        vel_i = int'(VEL_MAX);
      end
      // Rise compare is done without wrap; guard is taken against full hold.
      strike = (int'(smp) > int'(last_level[ch]) + int'(rise_thr)) &&
               (int'(hold_cnt[ch]) < int'(HOLD_FULL) - int'(guard_band));
      if (strike) begin
        if (sounding[ch]) begin
          ev[n] = note_event(KIND_OFF, note_i[NOTE_W-1:0], '0);
          n++;
        end
        ev[n] = note_event(KIND_ON, note_i[NOTE_W-1:0], vel_i[VEL_W-1:0]);
        n++;
        hold_cnt[ch] = HOLD_FULL;
        sounding[ch] = 1'b1;
      end
      last_level[ch] = smp;
      // Release: counter ran out while the note was still sounding.
      if (hold_cnt[ch] == 0 && sounding[ch]) begin
        sounding[ch]   = 1'b0;
        ev[n]          = note_event(KIND_OFF, note_i[NOTE_W-1:0], '0);
        n++;
        last_level[ch] = '0;
      end
    end
    if (n > 0) begin
      ev[n-1].last = 1'b1;
    end
    for (int i = 0; i < n; i++) begin
      pending_events.push_back(ev[i]);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Input side. Inputs change on the falling edge; acceptance is seen at the
  // rising edge. valid stays up after a word until the next call or a rest.
  // ---------------------------------------------------------------------------
  task automatic send_word(op_e op, logic [CH_W-1:0] ch, logic [SMP_W-1:0] smp, logic sh);
    int unsigned gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 9);
      @(negedge clk_i);
      in_if.valid = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_if.valid   = 1'b1;
    in_if.op      = op;
    in_if.channel = ch;
    in_if.sample  = smp;
    in_if.shift   = sh;
    do @(posedge clk_i); while (!in_if.ready);
    predict_events(op, ch, smp, sh);
  endtask

  task automatic send_tick();
    send_word(OP_TICK, CH_W'($urandom_range(0, 3)), SMP_W'($urandom_range(0, 255)),
              1'($urandom_range(0, 1)));
  endtask

  task automatic sender_rest();
    @(negedge clk_i);
    in_if.valid = 1'b0;
  endtask

  // Sender pauses until every owed event is back, then lets the pipe settle:
  // words that make no event may still be in the evaluate stage.
  task automatic wait_drained();
    sender_rest();
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (DRAIN_SETTLE) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Register port: setup cycle then access cycle; pready is checked anyway.
  // ---------------------------------------------------------------------------
  function automatic logic [DATA_W-1:0] register_value(reg_idx_e idx);
    case (idx)
      REG_THRESHOLD: return DATA_W'(rise_thr);
      REG_GUARD:     return DATA_W'(guard_band);
      REG_BASE_NOTE: return DATA_W'(base_note_r);
      default:       return DATA_W'(midi_ch_r);
    endcase
  endfunction

  task automatic apb_access(reg_idx_e idx, logic wr, logic [DATA_W-1:0] wdata,
                            output logic [DATA_W-1:0] rdata);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = {idx, 2'b00};
    pwdata  = wdata;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic check_register(reg_idx_e idx);
    logic [DATA_W-1:0] rdata;
    apb_access(idx, 1'b0, '0, rdata);
    check_field($sformatf("register %s readback", idx.name()), int'(rdata),
                int'(register_value(idx)));
  endtask

  task automatic set_register(reg_idx_e idx, logic [DATA_W-1:0] val);
    logic [DATA_W-1:0] unused;
    apb_access(idx, 1'b1, val, unused);
    case (idx)
      REG_THRESHOLD: rise_thr    = val[SMP_W-1:0];
      REG_GUARD:     guard_band  = val[SMP_W-1:0];
      REG_BASE_NOTE: base_note_r = val[NOTE_W-1:0];
      default:       midi_ch_r   = val[MCH_W-1:0];
    endcase
    check_register(idx);
  endtask

  // Drains the core first, so registers are written only while it is idle.
  task automatic set_config(int thr, int grd, int base, int mch);
    wait_drained();
    set_register(REG_THRESHOLD, DATA_W'(thr));
    set_register(REG_GUARD,     DATA_W'(grd));
    set_register(REG_BASE_NOTE, DATA_W'(base));
    set_register(REG_MIDI_CH,   DATA_W'(mch));
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall bursts, plus the long hold-off.
  // ---------------------------------------------------------------------------
  initial begin : result_receiver
    int unsigned stall_left;
    stall_left   = 0;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (rx_hold_off != 0) begin
        out_if.ready = 1'b0;
        rx_hold_off--;
      end else if (stall_left != 0) begin
        out_if.ready = 1'b0;
        stall_left--;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_if.ready = 1'b0;
        stall_left   = $urandom_range(0, 8);
      end else begin
        out_if.ready = 1'b1;
      end
    end
  end

  // Every accepted event is held against the oldest owed one.
  always @(posedge clk_i) begin : event_checker
    evt_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_events.size() == 0) begin
        report_mismatch("event with none owed, note", int'(out_if.note), -1);
      end else begin
        want = pending_events.pop_front();
        check_field("kind",        int'(out_if.kind),        int'(want.kind));
        check_field("note",        int'(out_if.note),        int'(want.note));
        check_field("velocity",    int'(out_if.velocity),    int'(want.velocity));
        check_field("out_channel", int'(out_if.out_channel), int'(want.out_channel));
        check_field("last",        int'(out_if.last),        int'(want.last));
      end
    end
  end

  // Watchdog: too long with nothing moving on any port means a hang.
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || psel) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Registers must read back their reset values.
  task automatic test_register_reset();
    check_register(REG_THRESHOLD);
    check_register(REG_GUARD);
    check_register(REG_BASE_NOTE);
    check_register(REG_MIDI_CH);
  endtask

  // Reset settings: rise just under / just over threshold, both banks,
  // velocity clipping, ignored out-of-range channel, tick with junk fields.
  task automatic test_strike_basics();
    send_word(OP_SAMPLE, 2'd0, 8'd0,   1'b0);  // no rise at all
    send_word(OP_SAMPLE, 2'd1, 8'd6,   1'b0);  // rise equal to threshold
    send_word(OP_SAMPLE, 2'd1, 8'd13,  1'b0);  // one over: note-on, vel 26
    send_word(OP_SAMPLE, 2'd2, 8'd255, 1'b1);  // upper bank, full scale
    send_word(OP_SAMPLE, 2'd3, 8'd255, 1'b1);  // no such channel
    send_word(OP_TICK,   2'd3, 8'd255, 1'b1);
    send_word(OP_SAMPLE, 2'd0, 8'd64,  1'b0);  // 2*64 clips to 127
    send_word(OP_SAMPLE, 2'd1, 8'd63,  1'b0);  // still inside the guard window
  endtask

  // No guard: a sounding channel retriggers with note-off then note-on.
  task automatic test_retrigger();
    set_config(0, 0, int'(BASE_NOTE_RST), int'(MIDI_CH_RST));
    send_word(OP_TICK,   2'd0, 8'd0,  1'b0);
    send_word(OP_SAMPLE, 2'd0, 8'd65, 1'b1);  // off/on in upper bank
    send_word(OP_SAMPLE, 2'd1, 8'd14, 1'b0);
  endtask

  // Run every hold counter down to zero, then release on the next sample.
  task automatic test_release();
    repeat (int'(HOLD_FULL)) send_tick();
    send_word(OP_SAMPLE, 2'd0, 8'd0,   1'b1);  // release; note-off uses shift
    send_word(OP_SAMPLE, 2'd1, 8'd200, 1'b1);  // strike wins over release
    send_word(OP_SAMPLE, 2'd2, 8'd0,   1'b0);  // plain release
    send_word(OP_TICK,   2'd0, 8'd0,   1'b0);  // counters at zero stay there
  endtask

  // Register extremes: threshold too high to ever strike, note saturation,
  // guard at full blocking everything, lowest base note and MIDI channels.
  task automatic test_register_extremes();
    set_config(255, 0, 127, 15);
    send_word(OP_SAMPLE, 2'd0, 8'd255, 1'b0);  // prev + threshold reaches 255: no strike
    set_config(254, 0, 127, 15);
    send_word(OP_SAMPLE, 2'd0, 8'd255, 1'b0);  // previous sample 255 blocks the strike
    send_word(OP_SAMPLE, 2'd2, 8'd255, 1'b1);
    set_config(0, 255, 0, 0);
    send_word(OP_SAMPLE, 2'd1, 8'd0,   1'b0);
    send_word(OP_TICK,   2'd0, 8'd0,   1'b0);
    send_word(OP_SAMPLE, 2'd1, 8'd255, 1'b0);  // guard blocks any strike
    set_config(0, 0, 0, 0);
    send_word(OP_SAMPLE, 2'd0, 8'd0,   1'b0);
    send_word(OP_TICK,   2'd0, 8'd0,   1'b0);
    send_word(OP_SAMPLE, 2'd0, 8'd1,   1'b0);  // note 0, velocity 2
  endtask

  // Receiver holds off while the sender keeps making two-event words, so the
  // event queue fills and the input stalls; then the sender waits it out.
  task automatic test_backpressure();
    logic [CH_W-1:0] ch;
    set_config(0, 0, $urandom_range(0, 127), $urandom_range(0, 15));
    rx_hold_off = HOLD_OFF_LEN;
    for (int i = 0; i < 12; i++) begin
      ch = CH_W'(i % CHANNELS);
      send_word(OP_SAMPLE, ch, 8'd0, 1'($urandom_range(0, 1)));
      send_word(OP_TICK, 2'd0, 8'd0, 1'b0);
      send_word(OP_SAMPLE, ch, 8'd200, 1'($urandom_range(0, 1)));
    end
    wait_drained();
  endtask

  // Random traffic in phases with fresh settings each; mostly quiet/hit
  // sample patterns and ticks, some junk channels, rare short tick runs that
  // wear the hold counters down. The last phase runs without gaps on either side.
  task automatic test_random_traffic();
    int unsigned r;
    int unsigned lvl;
    int          thr;
    int          grd;
    logic [SMP_W-1:0] smp;
    for (int p = 0; p < PHASES; p++) begin
      thr = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 30);
      grd = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 100);
      set_config(thr, grd, $urandom_range(0, 127), $urandom_range(0, 15));
      if (p == PHASES - 1) begin
        calm = 1'b1;
      end
      for (int i = 0; i < PHASE_WORDS; i++) begin
        r = $urandom_range(0, 99);
        if (r < 2) begin
          repeat ($urandom_range(8, 32)) send_tick();
        end else if (r < 30) begin
          send_tick();
        end else if (r < 34) begin
          send_word(OP_SAMPLE, 2'd3, SMP_W'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)));
        end else begin
          lvl = $urandom_range(0, 2);
          if (lvl == 0) begin
            smp = SMP_W'($urandom_range(0, 30));
          end else if (lvl == 1) begin
            smp = SMP_W'($urandom_range(60, 255));
          end else begin
            smp = SMP_W'($urandom_range(0, 255));
          end
          send_word(OP_SAMPLE, CH_W'($urandom_range(0, CHANNELS - 1)), smp,
                    1'($urandom_range(0, 1)));
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence: reset once, then each test in turn, then drain and verdict.
  // ---------------------------------------------------------------------------
  initial begin
    in_if.valid   = 1'b0;
    in_if.op      = OP_SAMPLE;
    in_if.channel = '0;
    in_if.sample  = '0;
    in_if.shift   = 1'b0;
    shadow_reset();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_register_reset();
    test_strike_basics();
    test_retrigger();
    test_release();
    test_register_extremes();
    test_backpressure();
    test_random_traffic();

    wait_drained();
    repeat (DRAIN_SETTLE) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
